// File: hdl/fpcsu_pkg.sv
// Package: shared types, operation codes and constants of the FP compare/status unit.
package fpcsu_pkg;

    localparam logic [2:0] OP_FCMPU  = 3'd0;
    localparam logic [2:0] OP_FCMPO  = 3'd1;
    localparam logic [2:0] OP_MCRFS  = 3'd2;
    localparam logic [2:0] OP_MTFSF  = 3'd3;
    localparam logic [2:0] OP_MTFSB0 = 3'd4;
    localparam logic [2:0] OP_MTFSB1 = 3'd5;

    localparam logic [3:0] CODE_LESS      = 4'd8;
    localparam logic [3:0] CODE_GREATER   = 4'd4;
    localparam logic [3:0] CODE_EQUAL     = 4'd2;
    localparam logic [3:0] CODE_UNORDERED = 4'd1;
    localparam logic [3:0] CODE_NONE      = 4'd0;

    localparam logic [31:0] STATUS_CODE_KEEP = 32'hffff0fff;
    localparam logic [31:0] STATUS_SNAN_BIT  = 32'h01000000;

    localparam logic [1:0] REG_FP_ENABLED = 2'd0;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] value_a;
        logic [63:0] value_b;
        logic [2:0]  cr_dest;
        logic [2:0]  status_src_field;
        logic [7:0]  field_mask;
        logic [4:0]  bit_number;
    } fpcsu_in_t;

    typedef struct packed {
        logic [31:0] status_out;
        logic [31:0] cond_out;
        logic [3:0]  compare_code;
        logic        fp_unavailable;
    } fpcsu_out_t;

    typedef struct packed {
        logic [3:0] code;
        logic       snan;
    } fpcsu_cmp_t;

endpackage

// File: hdl/fpcsu_stream_if.sv
// Interfaces: valid/ready channels for instruction and result transfers.
interface fpcsu_in_if;
    import fpcsu_pkg::*;
    logic      valid;
    logic      ready;
    fpcsu_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpcsu_out_if;
    import fpcsu_pkg::*;
    logic       valid;
    logic       ready;
    fpcsu_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/fpcsu_compare.sv
// Compare: IEEE double ordering on bit patterns and signaling-NaN detection.
module fpcsu_compare (
    input  logic [63:0]            value_a,
    input  logic [63:0]            value_b,
    output fpcsu_pkg::fpcsu_cmp_t  result
);
    import fpcsu_pkg::*;

    logic nan_a, nan_b;
    logic [63:0] key_a, key_b;

    function automatic logic [63:0] order_key(input logic [63:0] v);
        logic [63:0] k;
        if (v[62:0] == 63'd0)
            k = {1'b1, 63'd0};
        else if (v[63])
            k = ~v;
        else
            k = {1'b1, v[62:0]};
        return k;
    endfunction

    assign nan_a = (&value_a[62:52]) && (value_a[51:0] != 52'd0);
    assign nan_b = (&value_b[62:52]) && (value_b[51:0] != 52'd0);
    assign key_a = order_key(value_a);
    assign key_b = order_key(value_b);

    always_comb
    begin
        if (nan_a || nan_b)
            result.code = CODE_UNORDERED;
        else if (key_a < key_b)
            result.code = CODE_LESS;
        else if (key_a > key_b)
            result.code = CODE_GREATER;
        else
            result.code = CODE_EQUAL;
        result.snan = (nan_a && !value_a[51]) || (nan_b && !value_b[51]);
    end
endmodule

// File: hdl/fp_compare_status_unit.sv
// Top level: FP compare and status-control unit with APB configuration.
// Result: each input transfer's result is written into the output register in the cycle after the transfer.
// Throughput: one instruction per cycle; the output register alone holds the result
//   and an input is taken whenever that register is empty or being drained.
// Reset: rst_n asynchronous active low clears status word, condition register,
//   fp_enabled and the output valid flag.
module fp_compare_status_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fpcsu_in_if.sink    in_ch,
    fpcsu_out_if.source out_ch
);
    import fpcsu_pkg::*;

    logic        fp_enabled_reg;
    logic [31:0] status_reg, status_next;
    logic [31:0] cond_reg, cond_next;
    logic        out_valid_reg;
    fpcsu_out_t  out_data_reg, out_data_next;
    fpcsu_cmp_t  cmp;
    logic        take;
    logic [31:0] mask;
    logic [4:0]  cr_shift;
    logic [4:0]  src_shift;
    logic [4:0]  bit_pos;

    // APB: single register at address 0, always ready.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FP_ENABLED) ? {31'd0, fp_enabled_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fp_enabled_reg <= 1'b0;
        else if (psel && penable && pwrite && (paddr == REG_FP_ENABLED))
            fp_enabled_reg <= pwdata[0];
    end

    fpcsu_compare u_compare (
        .value_a (in_ch.data.value_a),
        .value_b (in_ch.data.value_b),
        .result  (cmp)
    );

    // Accept whenever the output register is empty or its result transfers now.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign take        = in_ch.valid && in_ch.ready;

    assign cr_shift  = 5'(4 * (7 - int'(in_ch.data.cr_dest)));
    assign src_shift = 5'(28 - 4 * int'(in_ch.data.status_src_field));
    assign bit_pos   = 5'd31 - in_ch.data.bit_number;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
            mask[4*k +: 4] = {4{in_ch.data.field_mask[k]}};
    end

    always_comb
    begin
        status_next = status_reg;
        cond_next   = cond_reg;
        out_data_next.compare_code   = CODE_NONE;
        out_data_next.fp_unavailable = 1'b0;
        unique case (in_ch.data.operation)
            OP_FCMPU, OP_FCMPO:
            begin
                if (!fp_enabled_reg)
                    out_data_next.fp_unavailable = 1'b1;
                else
                begin
                    // Drop the code into FPSCR[15:12] and the chosen CR field.
                    out_data_next.compare_code = cmp.code;
                    status_next = (status_reg & STATUS_CODE_KEEP) | {16'd0, cmp.code, 12'd0};
                    if (cmp.snan)
                        status_next = status_next | STATUS_SNAN_BIT;
                    cond_next = (cond_reg & ~(32'hf << cr_shift))
                              | ({28'd0, cmp.code} << cr_shift);
                end
            end
            OP_MCRFS:
                cond_next = (cond_reg & ~(32'hf << cr_shift))
                          | (((status_reg >> src_shift) & 32'hf) << cr_shift);
            OP_MTFSF:
                status_next = (in_ch.data.value_b[31:0] & mask) | (status_reg & ~mask);
            OP_MTFSB0:
                status_next = status_reg & ~(32'd1 << bit_pos);
            OP_MTFSB1:
                status_next = status_reg | (32'd1 << bit_pos);
            default:
            begin
                status_next = status_reg;
                cond_next   = cond_reg;
            end
        endcase
        out_data_next.status_out = status_next;
        out_data_next.cond_out   = cond_next;
    end

    // Advance architectural state and the output register on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= 32'd0;
            cond_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                status_reg    <= status_next;
                cond_reg      <= cond_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= out_data_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // A stalled result must not be overwritten by a new input.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("input accepted over stalled result");
    // The reported status matches the held status word.
    a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.status_out == status_reg))
        else $error("status output disagrees with state");
    // A refused compare never carries a code.
    a_unavail_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.fp_unavailable) |->
        (out_data_reg.compare_code == CODE_NONE))
        else $error("refused compare carries a code");
`endif

endmodule
